@@ sv/lpd_pkg.sv @@
package lpd_pkg;

    // Lane count and ADC resolution.
    localparam int LANES       = 3;
    localparam int SAMPLE_BITS = 12;

    // Width of the lane field on the port, and of a state memory address.
    localparam int LANE_BITS = 2;
    localparam int LANE_AW   = (LANES > 1) ? $clog2(LANES) : 1;

    // Per-lane state widths.
    localparam int HIST_BITS = 8;
    localparam int RUN_BITS  = 16;
    localparam int LAP_BITS  = 8;

    localparam logic [HIST_BITS-1:0] LAP_PATTERN   = 8'h03;
    localparam logic [HIST_BITS-1:0] HISTORY_RESET = 8'hFF;
    localparam logic [RUN_BITS-1:0]  RUN_MAX       = 16'hFFFF;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SAMPLE_BITS-1:0] RESET_MARGIN = SAMPLE_BITS'(100);
    localparam logic [RUN_BITS-1:0]    RESET_LIMIT  = RUN_BITS'(1000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASELINE0 = 3'd0,
        CFG_BASELINE1 = 3'd1,
        CFG_BASELINE2 = 3'd2,
        CFG_MARGIN    = 3'd3,
        CFG_LIMIT     = 3'd4
    } cfg_index_t;

    // One entry of the lane state memory.
    typedef struct packed {
        logic [HIST_BITS-1:0] history;
        logic [RUN_BITS-1:0]  run_count;
        logic [LAP_BITS-1:0]  laps;
    } lane_state_t;

    localparam int STATE_BITS = $bits(lane_state_t);

endpackage

@@ sv/lpd_ram.sv @@
module lpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/lane_pass_detector_lap_counter.sv @@
// An accepted sample has its lane state read from memory and its lane and sample held in the
// update stage; the updated result then goes to the output register. Throughput: one sample
// per cycle while the output is not stalled, set by the single read-modify-write pass
// over the state memory; a back-to-back sample for the same lane takes the forwarded state.
// Reset (rst_n low, asynchronous): all lanes read as history all ones, zero run and zero laps
// through per-lane valid bits; buzzer clear, baselines zero, margin 100, limit 1000.
module lane_pass_detector_lap_counter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [lpd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lpd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Sample channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lpd_pkg::LANE_BITS-1:0]        lane,
    input  logic [lpd_pkg::SAMPLE_BITS-1:0]      sample,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 detect,
    output logic                                 lap_event,
    output logic [lpd_pkg::LAP_BITS-1:0]         lap_count,
    output logic                                 timeout_alarm,
    output logic                                 buzzer
);

    // Configuration registers
    logic [lpd_pkg::SAMPLE_BITS-1:0] baseline_reg [lpd_pkg::LANES];
    logic [lpd_pkg::SAMPLE_BITS-1:0] margin_reg;
    logic [lpd_pkg::RUN_BITS-1:0]    limit_reg;

    // Update stage
    logic                            s1_valid_reg;
    logic [lpd_pkg::LANE_BITS-1:0]   s1_lane_reg;
    logic [lpd_pkg::SAMPLE_BITS-1:0] s1_sample_reg;
    logic                            fwd_hit_reg;
    lpd_pkg::lane_state_t            fwd_state_reg;
    logic [lpd_pkg::LANES-1:0]       entry_valid_reg;
    logic                            buzzer_reg;
    logic                            buzzer_next;

    // Output register
    logic                            out_valid_reg;
    logic                            out_detect_reg;
    logic                            out_lap_reg;
    logic [lpd_pkg::LAP_BITS-1:0]    out_laps_reg;
    logic                            out_alarm_reg;
    logic                            out_buzzer_reg;

    logic                            in_accept;
    logic                            s1_adv;
    logic                            s1_in_range;
    logic [lpd_pkg::LANE_AW-1:0]     s1_addr;
    logic [lpd_pkg::LANE_AW-1:0]     in_addr;
    logic [lpd_pkg::STATE_BITS-1:0]  ram_rdata;
    lpd_pkg::lane_state_t            state_cur;
    lpd_pkg::lane_state_t            state_new;
    logic [lpd_pkg::SAMPLE_BITS-1:0] base_sel;
    logic [lpd_pkg::SAMPLE_BITS:0]   upper_bound;
    logic [lpd_pkg::SAMPLE_BITS:0]   sample_plus_margin;
    logic                            det;
    logic                            alarm;
    logic                            lap;
    logic                            ram_we;

    // Handshake: the update stage moves on when the output register is free or drains.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign in_addr     = lane[lpd_pkg::LANE_AW-1:0];
    assign s1_addr     = s1_lane_reg[lpd_pkg::LANE_AW-1:0];
    assign s1_in_range = (s1_lane_reg < lpd_pkg::LANE_BITS'(lpd_pkg::LANES));
    assign ram_we      = s1_adv && s1_in_range;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lpd_pkg::LANES; k++)
            begin
                baseline_reg[k] <= '0;
            end
            margin_reg <= lpd_pkg::RESET_MARGIN;
            limit_reg  <= lpd_pkg::RESET_LIMIT;
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < lpd_pkg::LANES; k++)
            begin
                if (cfg_index == lpd_pkg::CFG_IDX_BITS'(k))
                begin
                    baseline_reg[k] <= cfg_data[lpd_pkg::SAMPLE_BITS-1:0];
                end
            end
            case (cfg_index)
                lpd_pkg::CFG_MARGIN: margin_reg <= cfg_data[lpd_pkg::SAMPLE_BITS-1:0];
                lpd_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[lpd_pkg::RUN_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Lane state memory: read on accept, written back when the update stage moves on with an in-range lane.
    lpd_ram #(
        .WIDTH (lpd_pkg::STATE_BITS),
        .DEPTH (lpd_pkg::LANES)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (state_new),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Current lane state: forwarded write, reset value for an unwritten entry, or memory.
    always_comb
    begin
        state_cur = lpd_pkg::lane_state_t'(ram_rdata);
        base_sel  = '0;
        if (s1_in_range)
        begin
            base_sel = baseline_reg[s1_addr];
            if (fwd_hit_reg)
            begin
                state_cur = fwd_state_reg;
            end
            else if (!entry_valid_reg[s1_addr])
            begin
                state_cur.history   = lpd_pkg::HISTORY_RESET;
                state_cur.run_count = '0;
                state_cur.laps      = '0;
            end
        end
    end

    // Window compare: sample >= base + margin, or sample + margin <= base.
    assign upper_bound        = {1'b0, base_sel} + {1'b0, margin_reg};
    assign sample_plus_margin = {1'b0, s1_sample_reg} + {1'b0, margin_reg};
    assign det = ({1'b0, s1_sample_reg} >= upper_bound)
              || (sample_plus_margin <= {1'b0, base_sel});

    // Lane update: history shift, saturating run count, lap test and buzzer.
    always_comb
    begin
        state_new.history = {state_cur.history[lpd_pkg::HIST_BITS-2:0], !det};
        if (!det)
        begin
            state_new.run_count = '0;
        end
        else if (state_cur.run_count == lpd_pkg::RUN_MAX)
        begin
            state_new.run_count = state_cur.run_count;
        end
        else
        begin
            state_new.run_count = state_cur.run_count + 1'b1;
        end
        alarm = (state_new.run_count > limit_reg);
        lap   = (state_new.history == lpd_pkg::LAP_PATTERN)
             && (state_new.run_count < limit_reg);
        state_new.laps = state_cur.laps + lpd_pkg::LAP_BITS'(lap);

        buzzer_next = buzzer_reg;
        if (s1_in_range)
        begin
            if (lap)
            begin
                buzzer_next = 1'b0;
            end
            else if (alarm)
            begin
                buzzer_next = 1'b1;
            end
        end
    end

    // Control state of the update stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            entry_valid_reg <= '0;
            buzzer_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (in_accept)
            begin
                fwd_hit_reg <= ram_we && (lane == s1_lane_reg);
            end

            if (ram_we)
            begin
                entry_valid_reg[s1_addr] <= 1'b1;
            end

            if (s1_adv)
            begin
                buzzer_reg    <= buzzer_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_lane_reg   <= lane;
            s1_sample_reg <= sample;
        end
        if (ram_we)
        begin
            fwd_state_reg <= state_new;
        end
        if (s1_adv)
        begin
            out_detect_reg <= s1_in_range && det;
            out_lap_reg    <= s1_in_range && lap;
            out_laps_reg   <= s1_in_range ? state_new.laps : '0;
            out_alarm_reg  <= s1_in_range && alarm;
            out_buzzer_reg <= buzzer_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign detect        = out_detect_reg;
    assign lap_event     = out_lap_reg;
    assign lap_count     = out_laps_reg;
    assign timeout_alarm = out_alarm_reg;
    assign buzzer        = out_buzzer_reg;

endmodule

@@ sv/lpd_checker.sv @@
module lpd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         detect,
    input  logic                         lap_event,
    input  logic [lpd_pkg::LAP_BITS-1:0] lap_count,
    input  logic                         timeout_alarm,
    input  logic                         buzzer
);

    // A stalled result beat stays and holds its lap count and buzzer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lap_count) && $stable(buzzer))
    else $error("result beat dropped or changed while stalled");

    // A lap always leaves the shared buzzer clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lap_event |-> !buzzer)
    else $error("buzzer set after a counted lap");

    // A lap closes on a miss, so it never comes with a detect.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lap_event |-> !detect)
    else $error("lap counted on a detect");

    // An alarm needs a running detect and raises the buzzer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timeout_alarm |-> detect && buzzer && !lap_event)
    else $error("timeout alarm without detect or buzzer");

endmodule

bind lane_pass_detector_lap_counter lpd_checker u_lpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .detect        (detect),
    .lap_event     (lap_event),
    .lap_count     (lap_count),
    .timeout_alarm (timeout_alarm),
    .buzzer        (buzzer)
);
